// ----- rtl/lecr_pkg.sv -----
package lecr_pkg;

  // echo codes carried to the output
  typedef enum logic [1:0] {
    ECHO_NONE  = 2'd0,
    ECHO_BYTE  = 2'd1,
    ECHO_ERASE = 2'd2,
    ECHO_EOL   = 2'd3
  } echo_kind_t;

  // command codes
  typedef enum logic [2:0] {
    CMD_HELP     = 3'd0,
    CMD_RESET    = 3'd1,
    CMD_REGTEST  = 3'd2,
    CMD_DATATEST = 3'd3,
    CMD_HEADTAIL = 3'd4,
    CMD_UNKNOWN  = 3'd5
  } cmd_code_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_DATA,
    BK_FLUSH,
    BK_RESULT
  } back_state_t;

  // request passed from front end to back end
  typedef struct packed {
    echo_kind_t  kind;
    logic [7:0]  data;
  } req_t;

  // special characters
  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_NUL   = 8'd0;

  // token counter saturates here
  localparam logic [2:0] TOK_MAX = 3'd5;

  // crc-32, reflected
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // command word hashes
  localparam logic [31:0] H_HELP     = 32'h0887_5cac;
  localparam logic [31:0] H_RESET    = 32'ha730_c915;
  localparam logic [31:0] H_REGTEST  = 32'h8f0a_dd03;
  localparam logic [31:0] H_DATATEST = 32'he022_0641;
  localparam logic [31:0] H_HEADTAIL = 32'h84c6_7266;

  // data test mode hashes
  localparam logic [31:0] H_DUAL_LINE = 32'hffd8_6266;
  localparam logic [31:0] H_DUAL_IO   = 32'h357f_4428;
  localparam logic [31:0] H_QUAD_LINE = 32'h96c4_4df9;
  localparam logic [31:0] H_QUAD_IO   = 32'hc52d_dfae;

  // one byte through the crc, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] ch);
    logic [31:0] c;
    c = crc;
    for (int j = 0; j < 8; j++) begin
      if (c[0] ^ ch[j]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/lecr_ram.sv -----
module lecr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/lecr_front.sv -----
module lecr_front #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_rx_byte,
  output logic                             req_valid,
  input  logic                             req_ready,
  output lecr_pkg::req_t                   req,
  output logic                             mem_we,
  output logic [$clog2(LINE_CAPACITY)-1:0] mem_waddr,
  output logic [7:0]                       mem_wdata,
  output logic [$clog2(LINE_CAPACITY)-1:0] line_len,
  input  logic                             line_done
);
  import lecr_pkg::*;

  localparam int FW = $clog2(LINE_CAPACITY);
  localparam logic [FW-1:0] FILL_MAX = FW'(LINE_CAPACITY - 2);

  logic [FW-1:0] fill_r, fill_nxt;
  logic          lock_r, lock_nxt;
  logic          accept;

  // no new bytes while a line is being parsed
  assign in_ready  = !lock_r && req_ready;
  assign accept    = in_valid && in_ready;
  assign req_valid = accept;
  assign mem_waddr = fill_r;
  assign mem_wdata = in_rx_byte;
  assign line_len  = fill_r;

  // classify the byte
  always_comb begin
    fill_nxt  = fill_r;
    lock_nxt  = lock_r;
    mem_we    = 1'b0;
    req.kind  = ECHO_NONE;
    req.data  = CHAR_NUL;
    if (line_done) begin
      fill_nxt = '0;
      lock_nxt = 1'b0;
    end
    if (accept) begin
      if (in_rx_byte == CHAR_LF || in_rx_byte == CHAR_CR) begin
        req.kind = ECHO_EOL;
        lock_nxt = 1'b1;
      end else if (in_rx_byte == CHAR_BS) begin
        if (fill_r != '0) begin
          fill_nxt = fill_r - FW'(1);
          req.kind = ECHO_ERASE;
        end
      end else if (fill_r < FILL_MAX) begin
        mem_we   = 1'b1;
        fill_nxt = fill_r + FW'(1);
        req.kind = ECHO_BYTE;
        req.data = in_rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      lock_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      lock_r <= lock_nxt;
    end
  end

endmodule

// ----- rtl/lecr_queue.sv -----
module lecr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  lecr_pkg::req_t wr_req,
  output logic           rd_valid,
  input  logic           rd_ready,
  output lecr_pkg::req_t rd_req
);
  import lecr_pkg::*;

  req_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_req   = slot_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointer and count update
  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wr_req;
    end
  end

endmodule

// ----- rtl/lecr_back.sv -----
module lecr_back #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  lecr_pkg::req_t                   req,
  output logic [$clog2(LINE_CAPACITY)-1:0] mem_raddr,
  input  logic [7:0]                       mem_rdata,
  input  logic [$clog2(LINE_CAPACITY)-1:0] line_len,
  output logic                             line_done,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_echo_kind,
  output logic [7:0]                       out_echo_byte,
  output logic                             out_command_found,
  output logic [2:0]                       out_command_code,
  output logic [31:0]                      out_command_hash,
  output logic [2:0]                       out_lines_used,
  output logic                             out_multiline_address,
  output logic [2:0]                       out_param_count
);
  import lecr_pkg::*;

  localparam int FW = $clog2(LINE_CAPACITY);

  back_state_t state_r, state_nxt;
  logic [FW-1:0] idx_r, idx_nxt;
  logic [2:0]    tok_r, tok_nxt;
  logic          in_tok_r, in_tok_nxt;
  logic [31:0]   crc_r, crc_nxt;
  logic [31:0]   cmd_hash_r, cmd_hash_nxt;
  logic [31:0]   par_hash_r, par_hash_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [1:0]  echo_kind_r;
  logic [7:0]  echo_byte_r;
  logic        found_r;
  logic [2:0]  code_r;
  logic [31:0] hash_r;
  logic [2:0]  lines_r;
  logic        multi_r;
  logic [2:0]  pcount_r;

  logic        out_free;
  logic        load;
  logic        proc;
  logic        sp;
  logic [1:0]  ld_kind;
  logic [7:0]  ld_byte;
  logic        ld_found;
  cmd_code_t   ld_code;
  logic [31:0] ld_hash;
  logic [2:0]  ld_lines;
  logic        ld_multi;
  logic [2:0]  ld_pcount;
  cmd_code_t   res_code;

  assign out_free  = !out_valid_r || out_ready;
  assign mem_raddr = idx_r;

  // command lookup from the stored hashes
  always_comb begin
    case (cmd_hash_r)
      H_HELP:     res_code = CMD_HELP;
      H_RESET:    res_code = CMD_RESET;
      H_REGTEST:  res_code = CMD_REGTEST;
      H_DATATEST: res_code = CMD_DATATEST;
      H_HEADTAIL: res_code = CMD_HEADTAIL;
      default:    res_code = CMD_UNKNOWN;
    endcase
  end

  // sequencer, tokenizer and output load
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    tok_nxt      = tok_r;
    in_tok_nxt   = in_tok_r;
    crc_nxt      = crc_r;
    cmd_hash_nxt = cmd_hash_r;
    par_hash_nxt = par_hash_r;
    req_ready    = 1'b0;
    line_done    = 1'b0;
    load         = 1'b0;
    proc         = 1'b0;
    ld_kind      = ECHO_NONE;
    ld_byte      = CHAR_NUL;
    ld_found     = 1'b0;
    ld_code      = CMD_HELP;
    ld_hash      = '0;
    ld_lines     = 3'd1;
    ld_multi     = 1'b0;
    ld_pcount    = 3'd0;
    sp           = (state_r == BK_FLUSH) || (mem_rdata == CHAR_SPACE);

    case (state_r)
      BK_IDLE: begin
        if (req_valid) begin
          if (req.kind == ECHO_EOL) begin
            req_ready  = 1'b1;
            idx_nxt    = '0;
            tok_nxt    = 3'd0;
            in_tok_nxt = 1'b0;
            state_nxt  = BK_READ;
          end else if (out_free) begin
            req_ready = 1'b1;
            load      = 1'b1;
            ld_kind   = req.kind;
            ld_byte   = req.data;
          end
        end
      end
      BK_READ: begin
        if (idx_r == line_len) begin
          state_nxt = BK_FLUSH;
        end else begin
          state_nxt = BK_DATA;
        end
      end
      BK_DATA: begin
        if (mem_rdata == CHAR_NUL) begin
          state_nxt = BK_FLUSH;
        end else begin
          proc      = 1'b1;
          idx_nxt   = idx_r + FW'(1);
          state_nxt = BK_READ;
        end
      end
      BK_FLUSH: begin
        proc      = 1'b1;
        state_nxt = BK_RESULT;
      end
      BK_RESULT: begin
        if (out_free) begin
          load      = 1'b1;
          line_done = 1'b1;
          ld_kind   = ECHO_EOL;
          state_nxt = BK_IDLE;
          if (tok_r != 3'd0) begin
            ld_found  = 1'b1;
            ld_code   = res_code;
            ld_hash   = cmd_hash_r;
            ld_pcount = tok_r - 3'd1;
            if (res_code == CMD_DATATEST && tok_r >= 3'd2) begin
              case (par_hash_r)
                H_DUAL_LINE: ld_lines = 3'd2;
                H_DUAL_IO: begin
                  ld_lines = 3'd2;
                  ld_multi = 1'b1;
                end
                H_QUAD_LINE: ld_lines = 3'd4;
                H_QUAD_IO: begin
                  ld_lines = 3'd4;
                  ld_multi = 1'b1;
                end
                default: ld_lines = 3'd1;
              endcase
            end
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase

    // one character through the token splitter
    if (proc) begin
      if (!sp && !in_tok_r) begin
        in_tok_nxt = 1'b1;
        crc_nxt    = crc_byte(CRC_INIT, mem_rdata);
      end else if (!sp) begin
        crc_nxt = crc_byte(crc_r, mem_rdata);
      end else if (in_tok_r) begin
        in_tok_nxt = 1'b0;
        if (tok_r == 3'd0) begin
          cmd_hash_nxt = ~crc_r;
        end else if (tok_r == 3'd1) begin
          par_hash_nxt = ~crc_r;
        end
        if (tok_r < TOK_MAX) begin
          tok_nxt = tok_r + 3'd1;
        end
      end
    end

    out_valid_nxt = load || (out_valid_r && !out_ready);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    tok_r      <= tok_nxt;
    in_tok_r   <= in_tok_nxt;
    crc_r      <= crc_nxt;
    cmd_hash_r <= cmd_hash_nxt;
    par_hash_r <= par_hash_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      echo_kind_r <= ld_kind;
      echo_byte_r <= ld_byte;
      found_r     <= ld_found;
      code_r      <= ld_code;
      hash_r      <= ld_hash;
      lines_r     <= ld_lines;
      multi_r     <= ld_multi;
      pcount_r    <= ld_pcount;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_echo_kind         = echo_kind_r;
  assign out_echo_byte         = echo_byte_r;
  assign out_command_found     = found_r;
  assign out_command_code      = code_r;
  assign out_command_hash      = hash_r;
  assign out_lines_used        = lines_r;
  assign out_multiline_address = multi_r;
  assign out_param_count       = pcount_r;

endmodule

// ----- rtl/line_edit_command_recognizer_unit.sv -----
// channel   ports                                       direction
// in        in_valid, in_ready, in_rx_byte              request in
// out       out_valid, out_ready, out_echo_kind, out_echo_byte, out_command_found,
//           out_command_code, out_command_hash, out_lines_used,
//           out_multiline_address, out_param_count      request out
//
// with the queue and output free, an ordinary byte's result passes the queue slot
// and then the output register; up to two byte requests wait in the queue between
// the ends. a line end is taken from the queue; each character passes a read and
// a data state (ram read, crc byte step), then flush and result states close it;
// a zero byte adds a data state. no byte is taken until the line result is loaded.
// reset is synchronous and active low; the line store holds no reset value.
// a stalled output holds its result and backs up the queue, then the input.
module line_edit_command_recognizer_unit #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_echo_kind,
  output logic [7:0]  out_echo_byte,
  output logic        out_command_found,
  output logic [2:0]  out_command_code,
  output logic [31:0] out_command_hash,
  output logic [2:0]  out_lines_used,
  output logic        out_multiline_address,
  output logic [2:0]  out_param_count
);
  import lecr_pkg::*;

  localparam int FW = $clog2(LINE_CAPACITY);

  req_t          f_req, b_req;
  logic          f_valid, f_ready;
  logic          b_valid, b_ready;
  logic          mem_we;
  logic [FW-1:0] mem_waddr, mem_raddr, line_len;
  logic [7:0]    mem_wdata, mem_rdata;
  logic          line_done;

  // front end: editing and line store writes
  lecr_front #(.LINE_CAPACITY(LINE_CAPACITY)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_rx_byte(in_rx_byte),
    .req_valid (f_valid),
    .req_ready (f_ready),
    .req       (f_req),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .line_len  (line_len),
    .line_done (line_done)
  );

  // request queue between the two ends
  lecr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .wr_req  (f_req),
    .rd_valid(b_valid),
    .rd_ready(b_ready),
    .rd_req  (b_req)
  );

  // line store
  lecr_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY)) u_line_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // back end: tokenizer, hashing and result register
  lecr_back #(.LINE_CAPACITY(LINE_CAPACITY)) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .req_valid            (b_valid),
    .req_ready            (b_ready),
    .req                  (b_req),
    .mem_raddr            (mem_raddr),
    .mem_rdata            (mem_rdata),
    .line_len             (line_len),
    .line_done            (line_done),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_echo_kind        (out_echo_kind),
    .out_echo_byte        (out_echo_byte),
    .out_command_found    (out_command_found),
    .out_command_code     (out_command_code),
    .out_command_hash     (out_command_hash),
    .out_lines_used       (out_lines_used),
    .out_multiline_address(out_multiline_address),
    .out_param_count      (out_param_count)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import lecr_pkg::*;

  localparam int LINE_CAP = 64;
  localparam int HOLD_CYCLES = 400;

  typedef logic [7:0] byte_q_t[$];

  // one predicted result request
  typedef struct {
    echo_kind_t  kind;
    logic [7:0]  echo;
    logic        found;
    cmd_code_t   code;
    logic [31:0] hash;
    logic [2:0]  lines;
    logic        multi;
    logic [2:0]  params;
  } echo_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_echo_kind;
  logic [7:0]  out_echo_byte;
  logic        out_command_found;
  logic [2:0]  out_command_code;
  logic [31:0] out_command_hash;
  logic [2:0]  out_lines_used;
  logic        out_multiline_address;
  logic [2:0]  out_param_count;

  // bytes waiting to be sent and results waiting to arrive
  logic [7:0]   rx_pending[$];
  echo_result_t echo_expected[$];

  // shadow of the line store
  logic [7:0] line_buf[LINE_CAP];
  int         fill_level = 0;

  int mismatch_count = 0;
  int pushed = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // words that hash to the command and data mode values
  byte_q_t cmd_words[5];
  byte_q_t mode_words[4];

  line_edit_command_recognizer_unit #(
    .LINE_CAPACITY(LINE_CAP)
  ) i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_echo_kind         (out_echo_kind),
    .out_echo_byte         (out_echo_byte),
    .out_command_found     (out_command_found),
    .out_command_code      (out_command_code),
    .out_command_hash      (out_command_hash),
    .out_lines_used        (out_lines_used),
    .out_multiline_address (out_multiline_address),
    .out_param_count       (out_param_count)
  );

  always #5 clk = ~clk;

  // reflected crc-32 of a byte string
  function automatic logic [31:0] crc32_of(byte_q_t s);
    logic [31:0] c;
    logic [7:0]  ch;
    c = CRC_INIT;
    foreach (s[i]) begin
      ch = s[i];
      for (int j = 0; j < 8; j++) begin
        if (c[0] ^ ch[j]) begin
          c = (c >> 1) ^ CRC_POLY;
        end else begin
          c = c >> 1;
        end
      end
    end
    return ~c;
  endfunction

  // build a word in 0x60..0x7f whose crc is the target; the crc is affine
  // in the five low bits of each byte, so solve the system over gf(2)
  function automatic byte_q_t forge_word(logic [31:0] target);
    byte_q_t     w;
    logic [31:0] base, v, t;
    logic [31:0] basis[32];
    logic [63:0] bmask[32];
    bit          have[32];
    logic [63:0] m, pick;
    bit          ok, placed;
    for (int nb = 7; nb <= 12; nb++) begin
      w.delete();
      for (int k = 0; k < nb; k++) w.push_back(8'h60);
      base = crc32_of(w);
      for (int b = 0; b < 32; b++) have[b] = 1'b0;
      for (int k = 0; k < nb * 5; k++) begin
        w[k / 5] = 8'h60 | 8'(1 << (k % 5));
        v = crc32_of(w) ^ base;
        w[k / 5] = 8'h60;
        m = 64'd1 << k;
        placed = 1'b0;
        for (int b = 31; b >= 0; b--) begin
          if (!placed && v[b]) begin
            if (have[b]) begin
              v = v ^ basis[b];
              m = m ^ bmask[b];
            end else begin
              basis[b] = v;
              bmask[b] = m;
              have[b] = 1'b1;
              placed = 1'b1;
            end
          end
        end
      end
      t = target ^ base;
      pick = '0;
      ok = 1'b1;
      for (int b = 31; b >= 0; b--) begin
        if (t[b]) begin
          if (!have[b]) begin
            ok = 1'b0;
          end else begin
            t = t ^ basis[b];
            pick = pick ^ bmask[b];
          end
        end
      end
      if (ok) begin
        for (int k = 0; k < nb * 5; k++) begin
          if (pick[k]) w[k / 5] = w[k / 5] | 8'(1 << (k % 5));
        end
        return w;
      end
    end
    return w;
  endfunction

  function automatic logic [31:0] span_hash(int s, int e);
    byte_q_t q;
    for (int i = s; i < e; i++) q.push_back(line_buf[i]);
    return crc32_of(q);
  endfunction

  // line editor behavior for one received byte
  function automatic echo_result_t predict_echo(logic [7:0] rx);
    echo_result_t r;
    int          len, tok, tstart, cmd_s, cmd_e, p_s, p_e;
    bit          in_tok, sp;
    logic [31:0] ph;
    r = '{kind: ECHO_NONE, echo: 8'h00, found: 1'b0, code: CMD_HELP, hash: 32'h0,
          lines: 3'd1, multi: 1'b0, params: 3'd0};
    if (rx == CHAR_LF || rx == CHAR_CR) begin
      // line ends before the first zero byte
      len = 0;
      while (len < fill_level && line_buf[len] != CHAR_NUL) len++;
      tok = 0;
      tstart = 0;
      cmd_s = 0;
      cmd_e = 0;
      p_s = 0;
      p_e = 0;
      in_tok = 1'b0;
      for (int i = 0; i <= len; i++) begin
        sp = (i == len) ? 1'b1 : (line_buf[i] == CHAR_SPACE);
        if (!sp && !in_tok) begin
          in_tok = 1'b1;
          tstart = i;
        end else if (sp && in_tok) begin
          in_tok = 1'b0;
          if (tok == 0) begin
            cmd_s = tstart;
            cmd_e = i;
          end else if (tok == 1) begin
            p_s = tstart;
            p_e = i;
          end
          if (tok < int'(TOK_MAX)) tok++;
        end
      end
      r.kind = ECHO_EOL;
      if (tok > 0) begin
        r.found = 1'b1;
        r.hash = span_hash(cmd_s, cmd_e);
        r.params = 3'(tok - 1);
        case (r.hash)
          H_HELP:     r.code = CMD_HELP;
          H_RESET:    r.code = CMD_RESET;
          H_REGTEST:  r.code = CMD_REGTEST;
          H_DATATEST: r.code = CMD_DATATEST;
          H_HEADTAIL: r.code = CMD_HEADTAIL;
          default:    r.code = CMD_UNKNOWN;
        endcase
        // data test mode from the first parameter
        if (r.code == CMD_DATATEST && tok >= 2) begin
          ph = span_hash(p_s, p_e);
          case (ph)
            H_DUAL_LINE: begin r.lines = 3'd2; r.multi = 1'b0; end
            H_DUAL_IO:   begin r.lines = 3'd2; r.multi = 1'b1; end
            H_QUAD_LINE: begin r.lines = 3'd4; r.multi = 1'b0; end
            H_QUAD_IO:   begin r.lines = 3'd4; r.multi = 1'b1; end
            default: ;
          endcase
        end
      end
      fill_level = 0;
    end else if (rx == CHAR_BS) begin
      if (fill_level > 0) begin
        fill_level--;
        r.kind = ECHO_ERASE;
      end
    end else if (fill_level < LINE_CAP - 2) begin
      line_buf[fill_level] = rx;
      fill_level++;
      r.kind = ECHO_BYTE;
      r.echo = rx;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // driver: offer the next pending byte, hold it until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (rx_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_rx_byte <= rx_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: predict on each accepted byte, check each accepted result
  always @(posedge clk) begin
    echo_result_t e;
    if (rst_n) begin
      if (in_valid && in_ready) echo_expected.push_back(predict_echo(in_rx_byte));
      if (out_valid && out_ready) begin
        if (echo_expected.size() == 0) begin
          $error("result with no request waiting: echo_kind %0d", out_echo_kind);
          mismatch_count++;
        end else begin
          e = echo_expected.pop_front();
          check_field("echo_kind", 32'(e.kind), 32'(out_echo_kind));
          check_field("echo_byte", 32'(e.echo), 32'(out_echo_byte));
          check_field("command_found", 32'(e.found), 32'(out_command_found));
          check_field("command_code", 32'(e.code), 32'(out_command_code));
          check_field("command_hash", e.hash, out_command_hash);
          check_field("lines_used", 32'(e.lines), 32'(out_lines_used));
          check_field("multiline_address", 32'(e.multi), 32'(out_multiline_address));
          check_field("param_count", 32'(e.params), 32'(out_param_count));
        end
      end
    end
  end

  task automatic push_byte(logic [7:0] b);
    rx_pending.push_back(b);
    pushed++;
  endtask

  // type a word, now and then with a typo fixed by backspace
  task automatic push_word(byte_q_t w);
    foreach (w[i]) begin
      if ($urandom_range(0, 19) == 0) begin
        push_byte(8'($urandom_range(33, 126)));
        push_byte(CHAR_BS);
      end
      push_byte(w[i]);
    end
  endtask

  task automatic push_spaces(int n);
    for (int i = 0; i < n; i++) push_byte(CHAR_SPACE);
  endtask

  task automatic push_eol();
    push_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
  endtask

  function automatic byte_q_t random_word();
    byte_q_t w;
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) w.push_back(8'($urandom_range(33, 126)));
    return w;
  endfunction

  // line that reaches the store's fill limit or runs past it, then up to three backspaces and up to three new bytes
  task automatic push_long_line();
    int n;
    n = $urandom_range(62, 75);
    for (int i = 0; i < n; i++) push_byte(8'($urandom_range(32, 126)));
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) push_byte(CHAR_BS);
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) push_byte(8'($urandom_range(33, 126)));
    push_eol();
  endtask

  // mostly well-formed command lines, some long lines and raw noise
  task automatic push_random_line();
    int r, sel, nparams;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      push_spaces($urandom_range(0, 2));
      sel = $urandom_range(0, 6);
      if (sel < 5) push_word(cmd_words[sel]);
      else push_word(random_word());
      nparams = $urandom_range(0, 5);
      for (int p = 0; p < nparams; p++) begin
        push_spaces($urandom_range(1, 3));
        if (p == 0 && (sel == int'(CMD_DATATEST) || $urandom_range(0, 3) == 0)
            && $urandom_range(0, 4) != 0) begin
          push_word(mode_words[$urandom_range(0, 3)]);
        end else begin
          push_word(random_word());
        end
      end
      push_spaces($urandom_range(0, 2));
      push_eol();
      if ($urandom_range(0, 5) == 0) push_byte(CHAR_LF);
    end else if (r < 80) begin
      push_long_line();
    end else begin
      sel = $urandom_range(1, 12);
      for (int i = 0; i < sel; i++) push_byte(8'($urandom_range(0, 255)));
      push_eol();
    end
  endtask

  // every known command once, the data test with each mode and none
  task automatic push_known_lines();
    push_word(cmd_words[CMD_HELP]);
    push_eol();
    push_word(cmd_words[CMD_RESET]);
    push_spaces(1);
    push_word(random_word());
    push_eol();
    push_word(cmd_words[CMD_REGTEST]);
    push_eol();
    push_word(cmd_words[CMD_HEADTAIL]);
    push_eol();
    push_word(cmd_words[CMD_DATATEST]);
    push_eol();
    for (int k = 0; k < 4; k++) begin
      push_word(cmd_words[CMD_DATATEST]);
      push_spaces(1);
      push_word(mode_words[k]);
      push_eol();
    end
  endtask

  task automatic wait_drained();
    while (rx_pending.size() > 0 || in_valid || echo_expected.size() > 0) @(negedge clk);
  endtask

  // stimulus and end of run
  initial begin
    cmd_words[CMD_HELP] = forge_word(H_HELP);
    cmd_words[CMD_RESET] = forge_word(H_RESET);
    cmd_words[CMD_REGTEST] = forge_word(H_REGTEST);
    cmd_words[CMD_DATATEST] = forge_word(H_DATATEST);
    cmd_words[CMD_HEADTAIL] = forge_word(H_HEADTAIL);
    mode_words[0] = forge_word(H_DUAL_LINE);
    mode_words[1] = forge_word(H_DUAL_IO);
    mode_words[2] = forge_word(H_QUAD_LINE);
    mode_words[3] = forge_word(H_QUAD_IO);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase 1: sender idles a little, receiver a lot
    send_idle_pct <= 11;
    recv_idle_pct <= 68;

    // directed: backspace on empty line, byte extremes, erase past start
    push_byte(CHAR_BS);
    push_byte(8'hFF);
    push_byte(CHAR_NUL);
    push_byte(8'h61);
    push_byte(CHAR_BS);
    push_byte(CHAR_BS);
    push_byte(CHAR_BS);
    push_byte(CHAR_BS);
    push_byte(CHAR_LF);
    // empty and all-space lines
    push_spaces(3);
    push_byte(CHAR_CR);
    push_byte(CHAR_CR);
    // zero byte cuts the line short
    push_byte(8'h71);
    push_byte(CHAR_NUL);
    push_spaces(1);
    push_byte(8'h7A);
    push_byte(CHAR_CR);
    // zero byte right at the start
    push_byte(CHAR_NUL);
    push_byte(8'h41);
    push_byte(CHAR_LF);

    push_long_line();
    push_known_lines();
    while (pushed < 320) push_random_line();
    wait_drained();

    // phase 2: the other way round
    send_idle_pct <= 68;
    recv_idle_pct <= 11;
    push_known_lines();
    while (pushed < 640) push_random_line();
    wait_drained();

    // phase 3: no idling, one long receiver hold-off while bytes keep coming
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    while (pushed < 950) push_random_line();
    hold_req <= hold_req + 1;
    wait_drained();

    repeat (200) @(negedge clk);
    if (mismatch_count == 0 && echo_expected.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
